// ===== hw/rtl/stop_and_wait_frame_sender_top_assert.svh =====
// Assertion macros used by the checker file of the frame sender.
`ifndef STOP_AND_WAIT_FRAME_SENDER_TOP_ASSERT_SVH
`define STOP_AND_WAIT_FRAME_SENDER_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SWFS_ASSERT_HOLD(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SWFS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/swfs_pkg.sv =====
package swfs_pkg;

  // Operation codes carried on the input tuser.
  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_START = 2'd1;
  localparam logic [1:0] OP_RESP  = 2'd2;
  localparam logic [1:0] OP_TICK  = 2'd3;

  // Result status codes.
  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_WAIT   = 3'd1;
  localparam logic [2:0] ST_OK     = 3'd2;
  localparam logic [2:0] ST_FAIL   = 3'd3;
  localparam logic [2:0] ST_REJECT = 3'd4;

  // Configuration register indexes.
  localparam logic [1:0] CFG_FLAG     = 2'd0;
  localparam logic [1:0] CFG_ATTEMPTS = 2'd1;
  localparam logic [1:0] CFG_TIMEOUT  = 2'd2;

  // Configuration reset values.
  localparam logic [7:0]  FLAG_RST     = 8'd126;
  localparam logic [3:0]  ATTEMPTS_RST = 4'd3;
  localparam logic [15:0] TIMEOUT_RST  = 16'd3;

  // Frame layout: flag, address, control, check byte, payload, flag.
  localparam int unsigned HDR_BYTES = 4;
  localparam int unsigned FRAME_OVH = 5;

  // Port widths.
  localparam int unsigned IN_TDATA_W  = 40;
  localparam int unsigned IN_TUSER_W  = 2;
  localparam int unsigned OUT_TDATA_W = 8;
  localparam int unsigned OUT_TUSER_W = 4;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 16;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       load_byte;
    logic       start;
    logic       retry;
    logic       finish;
    logic       tick;
    logic       clr_timer;
    logic       put_single;
    logic [2:0] single_status;
    logic       frame_begin;
    logic       frame_emit;
  } swfs_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic busy;
    logic full;
    logic match;
    logic timed_out;
    logic attempts_zero;
    logic frame_last;
    logic out_free;
  } swfs_sts_t;

endpackage

// ===== hw/rtl/stop_and_wait_frame_sender_top.sv =====
// Items that give one result: the result is registered in the cycle after acceptance,
// one item per cycle while the output side keeps taking transfers.
// Frame-sending items: 5 + payload count bytes, one per cycle while the output takes them,
// from the output register; the next item is taken after the closing flag is loaded.
// Reset (rst_n low, synchronous) clears the transfer, empties the payload count and
// restores flag 126, three attempts and a timeout of three ticks.
module stop_and_wait_frame_sender_top #(
  parameter int unsigned MAX_DATA = 32
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // Input channel.
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // payload_byte, frame_address, frame_control, awaited_control, reply_control
  input  logic [swfs_pkg::IN_TDATA_W-1:0]    in_tdata,
  // operation
  input  logic [swfs_pkg::IN_TUSER_W-1:0]    in_tuser,
  // Result channel.
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // out_byte
  output logic [swfs_pkg::OUT_TDATA_W-1:0]   out_tdata,
  // last_of_run
  output logic                               out_tlast,
  // byte_valid, status
  output logic [swfs_pkg::OUT_TUSER_W-1:0]   out_tuser,
  // Configuration channel.
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [swfs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [swfs_pkg::CFG_DATA_W-1:0]    cfg_data
);

  swfs_pkg::swfs_cmd_t cmd;
  swfs_pkg::swfs_sts_t sts;

  // Configuration writes complete in the cycle they are offered.
  assign cfg_ready = 1'b1;

  swfs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .op        (in_tuser),
    .sts       (sts),
    .in_tready (in_tready),
    .cmd       (cmd)
  );

  swfs_dp #(
    .MAX_DATA (MAX_DATA)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tdata   (in_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

// ===== hw/rtl/swfs_ram.sv =====
module swfs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                                      clk,
  input  logic                                      wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                          wr_data,
  input  logic                                      rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                          rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hw/rtl/swfs_ctrl.sv =====
module swfs_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic [1:0]            op,
  input  swfs_pkg::swfs_sts_t   sts,
  output logic                  in_tready,
  output swfs_pkg::swfs_cmd_t   cmd
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_SEND = 1'b1;

  logic state_r;
  logic state_nxt;

  // Decode each accepted item into datapath commands; walk the frame in S_SEND.
  always_comb begin
    logic retry_path;
    retry_path = 1'b0;
    cmd        = '0;
    state_nxt  = state_r;
    in_tready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = sts.out_free;
        if (in_tvalid && sts.out_free) begin
          case (op)
            swfs_pkg::OP_LOAD: begin
              cmd.put_single = 1'b1;
              if (sts.busy || sts.full) begin
                cmd.single_status = swfs_pkg::ST_REJECT;
              end else begin
                cmd.load_byte     = 1'b1;
                cmd.single_status = swfs_pkg::ST_IDLE;
              end
            end
            swfs_pkg::OP_START: begin
              if (sts.busy) begin
                cmd.put_single    = 1'b1;
                cmd.single_status = swfs_pkg::ST_REJECT;
              end else begin
                cmd.start       = 1'b1;
                cmd.clr_timer   = 1'b1;
                cmd.frame_begin = 1'b1;
                state_nxt       = S_SEND;
              end
            end
            swfs_pkg::OP_RESP: begin
              if (!sts.busy) begin
                cmd.put_single    = 1'b1;
                cmd.single_status = swfs_pkg::ST_IDLE;
              end else if (sts.match) begin
                cmd.finish        = 1'b1;
                cmd.clr_timer     = 1'b1;
                cmd.put_single    = 1'b1;
                cmd.single_status = swfs_pkg::ST_OK;
              end else begin
                retry_path = 1'b1;
              end
            end
            swfs_pkg::OP_TICK: begin
              if (!sts.busy) begin
                cmd.put_single    = 1'b1;
                cmd.single_status = swfs_pkg::ST_IDLE;
              end else if (sts.timed_out) begin
                retry_path = 1'b1;
              end else begin
                cmd.tick          = 1'b1;
                cmd.put_single    = 1'b1;
                cmd.single_status = swfs_pkg::ST_WAIT;
              end
            end
            default: begin
              cmd.put_single    = 1'b1;
              cmd.single_status = swfs_pkg::ST_IDLE;
            end
          endcase
          // A mismatch or timeout either resends the frame or ends in failure.
          if (retry_path) begin
            if (sts.attempts_zero) begin
              cmd.finish        = 1'b1;
              cmd.clr_timer     = 1'b1;
              cmd.put_single    = 1'b1;
              cmd.single_status = swfs_pkg::ST_FAIL;
            end else begin
              cmd.retry       = 1'b1;
              cmd.clr_timer   = 1'b1;
              cmd.frame_begin = 1'b1;
              state_nxt       = S_SEND;
            end
          end
        end
      end
      S_SEND: begin
        if (sts.out_free) begin
          cmd.frame_emit = 1'b1;
          if (sts.frame_last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== hw/rtl/swfs_dp.sv =====
module swfs_dp #(
  parameter int unsigned MAX_DATA = 32
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  swfs_pkg::swfs_cmd_t                     cmd,
  output swfs_pkg::swfs_sts_t                     sts,
  input  logic [swfs_pkg::IN_TDATA_W-1:0]         in_tdata,
  input  logic                                    cfg_valid,
  input  logic [swfs_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [swfs_pkg::CFG_DATA_W-1:0]         cfg_data,
  input  logic                                    out_tready,
  output logic                                    out_tvalid,
  output logic [swfs_pkg::OUT_TDATA_W-1:0]        out_tdata,
  output logic                                    out_tlast,
  output logic [swfs_pkg::OUT_TUSER_W-1:0]        out_tuser
);

  localparam int unsigned CNT_W  = $clog2(MAX_DATA + 1);
  localparam int unsigned ADDR_W = (MAX_DATA > 1) ? $clog2(MAX_DATA) : 1;
  localparam int unsigned K_W    = $clog2(MAX_DATA + swfs_pkg::FRAME_OVH);

  // Input fields.
  logic [7:0] payload_byte;
  logic [7:0] frame_address;
  logic [7:0] frame_control;
  logic [7:0] awaited_control;
  logic [7:0] reply_control;

  // Configuration registers.
  logic [7:0]  flag_r;
  logic [3:0]  max_att_r;
  logic [15:0] timeout_r;

  // Transfer state.
  logic             busy_r, busy_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [7:0]       addr_r, ctrl_r, exp_r;
  logic [3:0]       att_r, att_nxt;
  logic [15:0]      timer_r, timer_nxt;
  logic [15:0]      timer_inc;
  logic [K_W-1:0]   k_r, k_nxt;

  // Output register.
  logic                               out_tvalid_r, out_tvalid_nxt;
  logic [swfs_pkg::OUT_TDATA_W-1:0]   out_tdata_r;
  logic                               out_tlast_r;
  logic [swfs_pkg::OUT_TUSER_W-1:0]   out_tuser_r;

  // Payload memory and frame byte selection.
  logic              out_free;
  logic              frame_last;
  logic [K_W-1:0]    pidx;
  logic              rd_en;
  logic [7:0]        rd_data;
  logic [7:0]        frame_byte;

  assign payload_byte    = in_tdata[7:0];
  assign frame_address   = in_tdata[15:8];
  assign frame_control   = in_tdata[23:16];
  assign awaited_control = in_tdata[31:24];
  assign reply_control   = in_tdata[39:32];

  assign timer_inc  = timer_r + 16'd1;
  assign out_free   = !out_tvalid_r || out_tready;
  assign frame_last = (k_r == (K_W'(count_r) + K_W'(swfs_pkg::HDR_BYTES)));

  // Status toward the controller.
  always_comb begin
    sts.busy          = busy_r;
    sts.full          = (count_r >= CNT_W'(MAX_DATA));
    sts.match         = (reply_control == exp_r);
    sts.timed_out     = (timer_inc >= timeout_r);
    sts.attempts_zero = (att_r == 4'd0);
    sts.frame_last    = frame_last;
    sts.out_free      = out_free;
  end

  // Payload byte j is fetched while frame byte 3 + j goes out.
  assign pidx  = k_r - K_W'(swfs_pkg::HDR_BYTES - 1);
  assign rd_en = cmd.frame_emit && (k_r >= K_W'(swfs_pkg::HDR_BYTES - 1)) &&
                 (pidx < K_W'(count_r));

  swfs_ram #(
    .WIDTH (8),
    .DEPTH (MAX_DATA)
  ) u_payload_ram (
    .clk     (clk),
    .wr_en   (cmd.load_byte),
    .wr_addr (count_r[ADDR_W-1:0]),
    .wr_data (payload_byte),
    .rd_en   (rd_en),
    .rd_addr (pidx[ADDR_W-1:0]),
    .rd_data (rd_data)
  );

  // Byte for the current frame position.
  always_comb begin
    if ((k_r == '0) || frame_last) begin
      frame_byte = flag_r;
    end else if (k_r == K_W'(1)) begin
      frame_byte = addr_r;
    end else if (k_r == K_W'(2)) begin
      frame_byte = ctrl_r;
    end else if (k_r == K_W'(3)) begin
      frame_byte = addr_r ^ ctrl_r;
    end else begin
      frame_byte = rd_data;
    end
  end

  // Next values of the transfer state.
  always_comb begin
    busy_nxt  = busy_r;
    count_nxt = count_r;
    att_nxt   = att_r;
    timer_nxt = timer_r;
    k_nxt     = k_r;
    if (cmd.start) begin
      busy_nxt = 1'b1;
      att_nxt  = max_att_r;
    end
    if (cmd.retry) begin
      att_nxt = att_r - 4'd1;
    end
    if (cmd.load_byte) begin
      count_nxt = count_r + CNT_W'(1);
    end
    if (cmd.finish) begin
      busy_nxt  = 1'b0;
      count_nxt = '0;
    end
    if (cmd.clr_timer) begin
      timer_nxt = 16'd0;
    end else if (cmd.tick) begin
      timer_nxt = timer_inc;
    end
    if (cmd.frame_begin) begin
      k_nxt = '0;
    end else if (cmd.frame_emit) begin
      k_nxt = k_r + K_W'(1);
    end
  end

  // Output register valid: loaded by a result, cleared once the transfer is taken.
  always_comb begin
    out_tvalid_nxt = out_tvalid_r;
    if (cmd.put_single || cmd.frame_emit) begin
      out_tvalid_nxt = 1'b1;
    end else if (out_tready) begin
      out_tvalid_nxt = 1'b0;
    end
  end

  // Control and configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flag_r       <= swfs_pkg::FLAG_RST;
      max_att_r    <= swfs_pkg::ATTEMPTS_RST;
      timeout_r    <= swfs_pkg::TIMEOUT_RST;
      busy_r       <= 1'b0;
      count_r      <= '0;
      att_r        <= 4'd0;
      timer_r      <= 16'd0;
      k_r          <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          swfs_pkg::CFG_FLAG:     flag_r    <= cfg_data[7:0];
          swfs_pkg::CFG_ATTEMPTS: max_att_r <= cfg_data[3:0];
          swfs_pkg::CFG_TIMEOUT:  timeout_r <= cfg_data;
          default: begin
          end
        endcase
      end
      busy_r       <= busy_nxt;
      count_r      <= count_nxt;
      att_r        <= att_nxt;
      timer_r      <= timer_nxt;
      k_r          <= k_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  // Saved frame header and awaited control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r <= 8'd0;
      ctrl_r <= 8'd0;
      exp_r  <= 8'd0;
    end else if (cmd.start) begin
      addr_r <= frame_address;
      ctrl_r <= frame_control;
      exp_r  <= awaited_control;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.put_single) begin
      out_tdata_r <= '0;
      out_tlast_r <= 1'b1;
      out_tuser_r <= {cmd.single_status, 1'b0};
    end else if (cmd.frame_emit) begin
      out_tdata_r <= frame_byte;
      out_tlast_r <= frame_last;
      out_tuser_r <= {swfs_pkg::ST_WAIT, 1'b1};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tlast  = out_tlast_r;
  assign out_tuser  = out_tuser_r;

endmodule

// ===== hw/rtl/swfs_checker.sv =====
`include "stop_and_wait_frame_sender_top_assert.svh"

module swfs_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_tready,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [swfs_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input logic                              out_tlast,
  input logic [swfs_pkg::OUT_TUSER_W-1:0]  out_tuser
);

  // A stalled result holds still until it is taken.
  `SWFS_ASSERT_NEXT(a_out_hold, clk, rst_n, (out_tvalid && !out_tready),
    (out_tvalid && $stable(out_tdata) && $stable(out_tlast) && $stable(out_tuser)),
    "stalled result changed")

  // A result without a frame byte is the only one of its item and carries a zero byte.
  `SWFS_ASSERT_HOLD(a_single_last, clk, rst_n, (out_tvalid && !out_tuser[0]),
    (out_tlast && (out_tdata == 8'd0)), "single result not last or not zero")

  // Every frame byte reports the waiting status.
  `SWFS_ASSERT_HOLD(a_frame_wait, clk, rst_n, (out_tvalid && out_tuser[0]),
    (out_tuser[3:1] == swfs_pkg::ST_WAIT), "frame byte without waiting status")

  // No input transfer is taken while a result waits to be taken.
  `SWFS_ASSERT_HOLD(a_in_blocked, clk, rst_n, (out_tvalid && !out_tready),
    (!in_tready), "input ready while a result waits")

endmodule

bind stop_and_wait_frame_sender_top swfs_checker u_swfs_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

  localparam int unsigned PAYLOAD_DEPTH = 32;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned CYCLE_LIMIT   = 600000;
  localparam int unsigned PHASE_ITEMS   = 43;
  localparam int unsigned PRINT_CAP     = 30;

  // One frame-sender result as it leaves the result channel.
  typedef struct packed {
    logic [7:0] octet;
    logic       octet_valid;
    logic       run_end;
    logic [2:0] status;
  } tx_result_t;

  logic                                clk = 1'b0;
  logic                                rst_n = 1'b0;
  logic                                in_tvalid = 1'b0;
  logic                                in_tready;
  logic [swfs_pkg::IN_TDATA_W-1:0]     in_tdata = '0;
  logic [swfs_pkg::IN_TUSER_W-1:0]     in_tuser = '0;
  logic                                out_tvalid;
  logic                                out_tready = 1'b0;
  logic [swfs_pkg::OUT_TDATA_W-1:0]    out_tdata;
  logic                                out_tlast;
  logic [swfs_pkg::OUT_TUSER_W-1:0]    out_tuser;
  logic                                cfg_valid = 1'b0;
  logic                                cfg_ready;
  logic [swfs_pkg::CFG_IDX_W-1:0]      cfg_index = '0;
  logic [swfs_pkg::CFG_DATA_W-1:0]     cfg_data = '0;

  // Register copies used by the frame predictor.
  logic [7:0]  flag_reg  = swfs_pkg::FLAG_RST;
  logic [3:0]  tries_reg = swfs_pkg::ATTEMPTS_RST;
  logic [15:0] tmo_reg   = swfs_pkg::TIMEOUT_RST;

  // Transfer state used by the frame predictor.
  logic [7:0]  buf_bytes [PAYLOAD_DEPTH];
  int unsigned buf_count  = 0;
  bit          xfer_busy  = 1'b0;
  logic [7:0]  hold_addr  = '0;
  logic [7:0]  hold_ctrl  = '0;
  logic [7:0]  hold_match = '0;
  logic [3:0]  tries_left = '0;
  logic [15:0] tick_cnt   = '0;

  tx_result_t  due_results [$];
  tx_result_t  head;
  int unsigned err_cnt      = 0;
  int unsigned useful_items = 0;
  int unsigned cycle_cnt    = 0;

  // Idle percentages and the receiver hold-off request.
  int unsigned tx_idle_pct    = 0;
  int unsigned rx_idle_pct    = 0;
  int unsigned stall_req_cnt  = 0;
  int unsigned stall_seen_cnt = 0;
  int unsigned stall_len      = 0;
  int unsigned stall_left     = 0;

  stop_and_wait_frame_sender_top #(
    .MAX_DATA(PAYLOAD_DEPTH)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .out_tuser (out_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_cnt = cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("stop_and_wait_frame_sender_top regression: fail");
      $finish;
    end
  end

  // Receiver: random stalls, or a long hold-off counted here when requested.
  always @(negedge clk) begin
    if (stall_seen_cnt != stall_req_cnt) begin
      stall_seen_cnt = stall_req_cnt;
      stall_left = stall_len;
    end
    if (stall_left > 0) begin
      stall_left = stall_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    err_cnt++;
    if (err_cnt <= PRINT_CAP)
      $display("MISMATCH cycle %0d: %s got 0x%0h wanted 0x%0h", cycle_cnt, what, got, want);
  endtask

  // Compare every result transfer with the oldest predicted one.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (due_results.size() == 0) begin
        report_mismatch("result with nothing predicted, byte", out_tdata, 0);
      end else begin
        head = due_results.pop_front();
        if (out_tdata !== head.octet)
          report_mismatch("out_byte", out_tdata, head.octet);
        if (out_tuser[0] !== head.octet_valid)
          report_mismatch("byte_valid", out_tuser[0], head.octet_valid);
        if (out_tlast !== head.run_end)
          report_mismatch("last_of_run", out_tlast, head.run_end);
        if (out_tuser[3:1] !== head.status)
          report_mismatch("status", out_tuser[3:1], head.status);
      end
    end
  end

  function automatic logic [7:0] rnd8();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [swfs_pkg::IN_TDATA_W-1:0] pack_item(input logic [7:0] pb,
      input logic [7:0] fa, input logic [7:0] fc, input logic [7:0] ac,
      input logic [7:0] rc);
    return {rc, ac, fc, fa, pb};
  endfunction

  function automatic void queue_status(input logic [2:0] st);
    due_results.push_back('{octet: 8'h00, octet_valid: 1'b0, run_end: 1'b1, status: st});
  endfunction

  function automatic void queue_octet(input logic [7:0] b, input bit ends);
    due_results.push_back('{octet: b, octet_valid: 1'b1, run_end: ends,
                            status: swfs_pkg::ST_WAIT});
  endfunction

  // A frame is flag, address, control, check byte, stored payload, flag.
  function automatic void queue_frame();
    queue_octet(flag_reg, 1'b0);
    queue_octet(hold_addr, 1'b0);
    queue_octet(hold_ctrl, 1'b0);
    queue_octet(hold_addr ^ hold_ctrl, 1'b0);
    for (int unsigned i = 0; i < buf_count; i++)
      queue_octet(buf_bytes[i], 1'b0);
    queue_octet(flag_reg, 1'b1);
    tick_cnt = '0;
  endfunction

  // Success or failure closes the transfer and empties the payload store.
  function automatic void close_transfer(input logic [2:0] st);
    xfer_busy = 1'b0;
    buf_count = 0;
    tick_cnt = '0;
    queue_status(st);
  endfunction

  function automatic void resend_or_fail();
    if (tries_left == 4'd0) begin
      close_transfer(swfs_pkg::ST_FAIL);
    end else begin
      tries_left = tries_left - 4'd1;
      queue_frame();
    end
  endfunction

  // Predicts the results of one accepted item; returns 1 if the block ignores it.
  function automatic bit predict_frame_results(input logic [1:0] op,
      input logic [swfs_pkg::IN_TDATA_W-1:0] d);
    if (op == swfs_pkg::OP_LOAD) begin
      if (xfer_busy || buf_count >= PAYLOAD_DEPTH) begin
        queue_status(swfs_pkg::ST_REJECT);
      end else begin
        buf_bytes[buf_count] = d[7:0];
        buf_count++;
        queue_status(swfs_pkg::ST_IDLE);
      end
      return 1'b0;
    end
    if (op == swfs_pkg::OP_START) begin
      if (xfer_busy) begin
        queue_status(swfs_pkg::ST_REJECT);
      end else begin
        hold_addr  = d[15:8];
        hold_ctrl  = d[23:16];
        hold_match = d[31:24];
        tries_left = tries_reg;
        xfer_busy  = 1'b1;
        queue_frame();
      end
      return 1'b0;
    end
    if (!xfer_busy) begin
      queue_status(swfs_pkg::ST_IDLE);
      return 1'b1;
    end
    if (op == swfs_pkg::OP_RESP) begin
      if (d[39:32] == hold_match)
        close_transfer(swfs_pkg::ST_OK);
      else
        resend_or_fail();
    end else begin
      tick_cnt = tick_cnt + 16'd1;
      if (tick_cnt >= tmo_reg)
        resend_or_fail();
      else
        queue_status(swfs_pkg::ST_WAIT);
    end
    return 1'b0;
  endfunction

  // Offers one item, with random idle cycles ahead of it, and predicts on acceptance.
  task automatic send_item(input logic [1:0] op,
      input logic [swfs_pkg::IN_TDATA_W-1:0] d);
    bit ignored;
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= d;
    do @(posedge clk); while (!in_tready);
    ignored = predict_frame_results(op, d);
    if (!ignored)
      useful_items++;
  endtask

  task automatic do_load(input logic [7:0] pb);
    send_item(swfs_pkg::OP_LOAD, pack_item(pb, rnd8(), rnd8(), rnd8(), rnd8()));
  endtask

  task automatic do_start(input logic [7:0] fa, input logic [7:0] fc, input logic [7:0] ac);
    send_item(swfs_pkg::OP_START, pack_item(rnd8(), fa, fc, ac, rnd8()));
  endtask

  task automatic do_reply(input logic [7:0] rc);
    send_item(swfs_pkg::OP_RESP, pack_item(rnd8(), rnd8(), rnd8(), rnd8(), rc));
  endtask

  task automatic do_tick();
    send_item(swfs_pkg::OP_TICK, pack_item(rnd8(), rnd8(), rnd8(), rnd8(), rnd8()));
  endtask

  // Drops the input valid and waits until every predicted result has come out.
  task automatic settle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register write; only called once the block is idle.
  task automatic write_reg(input logic [swfs_pkg::CFG_IDX_W-1:0] idx,
      input logic [15:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      swfs_pkg::CFG_FLAG:     flag_reg  = val[7:0];
      swfs_pkg::CFG_ATTEMPTS: tries_reg = val[3:0];
      swfs_pkg::CFG_TIMEOUT:  tmo_reg   = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Reset register values: idle items, rejects, timeout, mismatch and success.
  task automatic test_defaults_and_rejects();
    do_reply(8'h00);
    do_tick();
    do_load(8'h00);
    do_load(8'hFF);
    do_start(8'hFF, 8'h00, 8'h81);
    do_start(8'h12, 8'h34, 8'h56);
    do_load(8'h55);
    do_tick();
    do_tick();
    do_tick();
    do_reply(8'h7E);
    do_reply(8'h81);
    // Empty payload, every answer wrong until the attempts run out.
    do_start(8'h00, 8'hFF, 8'h00);
    repeat (4) do_reply(8'hFF);
    do_start(8'hA5, 8'h5A, 8'hFF);
    do_reply(8'hFF);
    settle();
  endtask

  // Full payload store, the load past it, and the emptied store afterwards.
  task automatic test_store_overflow();
    logic [7:0] ack;
    ack = rnd8();
    repeat (PAYLOAD_DEPTH) do_load(rnd8());
    do_load(rnd8());
    do_start(rnd8(), rnd8(), ack);
    do_reply(ack);
    do_start(rnd8(), rnd8(), ack);
    do_reply(ack);
    settle();
  endtask

  // Register extremes: zero attempts and timeout, then the largest values.
  task automatic test_register_extremes();
    write_reg(swfs_pkg::CFG_FLAG, {rnd8(), 8'h00});
    write_reg(swfs_pkg::CFG_ATTEMPTS, 16'hFFF0);
    write_reg(swfs_pkg::CFG_TIMEOUT, 16'h0000);
    do_load(8'h3C);
    do_start(8'h01, 8'h80, 8'h42);
    do_tick();
    do_start(8'h80, 8'h01, 8'h42);
    do_reply(8'h43);
    settle();
    write_reg(swfs_pkg::CFG_FLAG, {rnd8(), 8'hFF});
    write_reg(swfs_pkg::CFG_ATTEMPTS, 16'h000F);
    write_reg(swfs_pkg::CFG_TIMEOUT, 16'h0001);
    do_load(8'hC3);
    do_start(8'h7F, 8'hFE, 8'h00);
    repeat (3) do_tick();
    do_reply(8'h00);
    settle();
    write_reg(swfs_pkg::CFG_ATTEMPTS, 16'h0001);
    write_reg(swfs_pkg::CFG_TIMEOUT, 16'hFFFF);
    do_start(8'hFE, 8'h7F, 8'h99);
    repeat (5) do_tick();
    do_reply(8'h98);
    do_reply(8'h9A);
    settle();
  endtask

  // One transfer with random content, mostly well-formed, some noise.
  task automatic run_transfer();
    int unsigned n;
    int unsigned pick;
    logic [7:0]  ack;
    pick = $urandom_range(0, 19);
    if (pick < 14)
      n = $urandom_range(0, 4);
    else if (pick < 18)
      n = $urandom_range(5, 31);
    else
      n = $urandom_range(32, 34);
    if ($urandom_range(0, 7) == 0) begin
      if ($urandom_range(0, 1) == 0)
        do_tick();
      else
        do_reply(rnd8());
    end
    repeat (n) do_load(rnd8());
    ack = rnd8();
    do_start(rnd8(), rnd8(), ack);
    while (xfer_busy) begin
      pick = $urandom_range(0, 19);
      if (pick < 2) begin
        if (pick == 0)
          do_load(rnd8());
        else
          do_start(rnd8(), rnd8(), rnd8());
      end else if (pick < 10) begin
        do_reply(($urandom_range(0, 1) == 0) ? ack : rnd8());
      end else begin
        do_tick();
      end
    end
  endtask

  task automatic run_random_phase(input int unsigned tx_pct, input int unsigned rx_pct,
      input logic [15:0] attempts, input logic [15:0] timeout);
    int unsigned goal;
    write_reg(swfs_pkg::CFG_FLAG, {rnd8(), rnd8()});
    write_reg(swfs_pkg::CFG_ATTEMPTS, attempts);
    write_reg(swfs_pkg::CFG_TIMEOUT, timeout);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    goal = useful_items + PHASE_ITEMS;
    while (useful_items < goal) run_transfer();
    settle();
  endtask

  task automatic test_random_traffic();
    run_random_phase(9, 51, 16'd1, 16'd2);
    run_random_phase(51, 9, 16'd15, 16'($urandom_range(3, 8)));
    run_random_phase(0, 0, 16'($urandom_range(0, 15)), 16'($urandom_range(0, 6)));
  endtask

  // Receiver holds off while long frames keep coming, so the input stalls.
  task automatic test_output_hold_off();
    logic [7:0] ack;
    stall_len = 400;
    stall_req_cnt++;
    repeat (2) begin
      ack = rnd8();
      repeat (24) do_load(rnd8());
      do_start(rnd8(), rnd8(), ack);
      do_reply(ack ^ 8'h01);
      do_reply(ack);
    end
    settle();
  endtask

  initial begin
    tx_idle_pct = 9;
    rx_idle_pct = 51;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_defaults_and_rejects();
    test_store_overflow();
    test_register_extremes();
    test_output_hold_off();
    test_random_traffic();
    settle();
    if (err_cnt == 0)
      $display("stop_and_wait_frame_sender_top regression: pass");
    else
      $display("stop_and_wait_frame_sender_top regression: fail");
    $finish;
  end

endmodule

// ===== stop_and_wait_frame_sender_top.f =====
+incdir+hw/rtl
hw/rtl/swfs_pkg.sv
hw/rtl/swfs_ram.sv
hw/rtl/swfs_ctrl.sv
hw/rtl/swfs_dp.sv
hw/rtl/stop_and_wait_frame_sender_top.sv
hw/rtl/swfs_checker.sv
tb/sv/tb_top.sv
